// ===== rtl/socks_pkg.sv =====
// shared types and constants for the socks5 request parser
package socks_pkg;

   localparam int COUNT_WIDTH = 9;

   localparam logic [7:0] SOCKS_VERSION = 8'd5;
   localparam logic [7:0] RESERVED_VAL  = 8'h00;
   localparam logic [7:0] ATYP_IPV4     = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN   = 8'd3;
   localparam logic [7:0] ATYP_IPV6     = 8'd4;
   localparam logic [7:0] IPV4_LEN      = 8'd4;
   localparam logic [7:0] IPV6_LEN      = 8'd16;

   typedef enum logic [3:0] {
      PH_VER    = 4'd0,
      PH_CMD    = 4'd1,
      PH_RSV    = 4'd2,
      PH_ATYP   = 4'd3,
      PH_DOMLEN = 4'd4,
      PH_ADDR   = 4'd5,
      PH_PORTHI = 4'd6,
      PH_PORTLO = 4'd7,
      PH_SKIP   = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_VERSION   = 3'd1,
      ERR_RESERVED  = 3'd2,
      ERR_ATYP      = 3'd3,
      ERR_TRUNCATED = 3'd4
   } cause_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      phase_type              field_kind;
      logic [7:0]             field_index;
      logic [7:0]             byte_value;
      status_type             status;
      cause_type              error_cause;
      logic [7:0]             command_code;
      logic [7:0]             address_kind;
      logic [15:0]            dest_port;
      logic [COUNT_WIDTH-1:0] consumed_count;
   } rsp_type;

endpackage

// ===== rtl/socks5_request_parser.sv =====
// top level of the socks5 request parser
//
//   port group  direction  payload    handshake
//   req_        in         req_type   req_valid / req_stall
//   rsp_        out        rsp_type   rsp_valid / rsp_stall
//
// one byte per cycle while req_stall is low; each accepted beat yields one registered result beat
// the parser state advances in the accept cycle, so beats may come back to back
// a two-entry output buffer (register plus skid) decouples rsp_stall from req_stall
// req_stall rises only while both output entries are occupied
// reset is synchronous and returns the parser to expecting a version byte
module socks5_request_parser
   import socks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    accept;
   logic    buf_full;
   rsp_type step_result;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   socks_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .step_en  (accept),
      .req_data (req_data),
      .result   (step_result)
   );

   socks_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (step_result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

// ===== rtl/socks_parse.sv =====
// parser state machine: tags one byte per beat and updates request state
module socks_parse
   import socks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type req_data,
   output rsp_type result
);

   phase_type              phase_ff, phase_in;
   logic [7:0]             remaining_ff, remaining_in;
   logic [7:0]             position_ff, position_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0]             command_ff, command_in;
   logic [7:0]             atyp_ff, atyp_in;
   logic [7:0]             port_high_ff, port_high_in;
   logic                   ver_bad_ff, ver_bad_in;
   logic                   rsv_bad_ff, rsv_bad_in;

   logic [7:0] b;
   logic       eob;
   cause_type  cause;

   assign b   = req_data.data_byte;
   assign eob = req_data.end_of_buffer;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      position_in  = position_ff;
      count_in     = count_ff;
      command_in   = command_ff;
      atyp_in      = atyp_ff;
      port_high_in = port_high_ff;
      ver_bad_in   = ver_bad_ff;
      rsv_bad_in   = rsv_bad_ff;
      cause        = ERR_NONE;

      result            = '0;
      result.field_kind = phase_ff;
      result.byte_value = b;
      result.status     = ST_BUSY;
      result.error_cause = ERR_NONE;

      if (phase_ff != PH_SKIP) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end

      case (phase_ff)
         PH_VER: begin
            ver_bad_in = (b != SOCKS_VERSION);
            phase_in   = PH_CMD;
         end
         PH_CMD: begin
            command_in = b;
            phase_in   = PH_RSV;
         end
         PH_RSV: begin
            rsv_bad_in = (b != RESERVED_VAL);
            phase_in   = PH_ATYP;
         end
         PH_ATYP: begin
            atyp_in     = b;
            position_in = '0;
            // header checks are deferred to this byte
            if (ver_bad_ff) begin
               cause = ERR_VERSION;
            end else if (rsv_bad_ff) begin
               cause = ERR_RESERVED;
            end else if (b == ATYP_IPV4) begin
               remaining_in = IPV4_LEN;
               phase_in     = PH_ADDR;
            end else if (b == ATYP_DOMAIN) begin
               phase_in = PH_DOMLEN;
            end else if (b == ATYP_IPV6) begin
               remaining_in = IPV6_LEN;
               phase_in     = PH_ADDR;
            end else begin
               cause = ERR_ATYP;
            end
         end
         PH_DOMLEN: begin
            remaining_in = b;
            position_in  = '0;
            // empty domain skips straight to the port
            phase_in     = (b != 8'd0) ? PH_ADDR : PH_PORTHI;
         end
         PH_ADDR: begin
            result.field_index = position_ff;
            position_in  = position_ff + 8'd1;
            remaining_in = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) begin
               phase_in = PH_PORTHI;
            end
         end
         PH_PORTHI: begin
            port_high_in = b;
            phase_in     = PH_PORTLO;
         end
         PH_PORTLO: begin
            result.status         = ST_DONE;
            result.command_code   = command_ff;
            result.address_kind   = atyp_ff;
            result.dest_port      = {port_high_ff, b};
            result.consumed_count = count_in;
            phase_in              = PH_SKIP;
         end
         default: begin
            result.field_kind = PH_SKIP;
            phase_in          = PH_SKIP;
         end
      endcase

      if (cause != ERR_NONE) begin
         result.status      = ST_ERROR;
         result.error_cause = cause;
         phase_in           = PH_SKIP;
      end else if (eob && phase_ff != PH_SKIP && phase_ff != PH_PORTLO) begin
         result.status      = ST_ERROR;
         result.error_cause = ERR_TRUNCATED;
      end

      // last beat of the buffer restarts the parser
      if (eob) begin
         phase_in     = PH_VER;
         remaining_in = '0;
         position_in  = '0;
         count_in     = '0;
         command_in   = '0;
         atyp_in      = '0;
         port_high_in = '0;
         ver_bad_in   = 1'b0;
         rsv_bad_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_VER;
         remaining_ff <= '0;
         position_ff  <= '0;
         count_ff     <= '0;
         command_ff   <= '0;
         atyp_ff      <= '0;
         port_high_ff <= '0;
         ver_bad_ff   <= 1'b0;
         rsv_bad_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         position_ff  <= position_in;
         count_ff     <= count_in;
         command_ff   <= command_in;
         atyp_ff      <= atyp_in;
         port_high_ff <= port_high_in;
         ver_bad_ff   <= ver_bad_in;
         rsv_bad_ff   <= rsv_bad_in;
      end
   end

`ifndef SYNTHESIS
   a_eob_restarts: assert property (@(posedge clock) disable iff (reset)
      step_en && eob |=> phase_ff == PH_VER && count_ff == '0)
      else $error("parser did not restart after end of buffer");

   a_done_on_portlo: assert property (@(posedge clock) disable iff (reset)
      step_en && result.status == ST_DONE |-> phase_ff == PH_PORTLO)
      else $error("request complete outside port low byte");

   a_skip_holds: assert property (@(posedge clock) disable iff (reset)
      step_en && phase_ff == PH_SKIP && !eob |=> phase_ff == PH_SKIP)
      else $error("parser left trailing phase before end of buffer");
`endif

endmodule

// ===== rtl/socks_skid.sv =====
// result register with skid stage so the parser can take one further beat under stall
module socks_skid
   import socks_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    taken;

   assign taken     = out_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (taken) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (load) begin
         if (out_valid_ff && !taken) begin
            skid_in       = load_data;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = load_data;
            out_valid_in = 1'b1;
         end
      end else if (taken) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a beat while output is empty");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !load)
      else $error("beat loaded while skid stage is full");

   a_stalled_beat_stable: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stall |=> out_valid_ff && $stable(out_ff))
      else $error("stalled result beat changed");
`endif

endmodule
